// ----- design/npcb_pkg.sv -----
// ----------------------------------------------------------------------------
// npcb_pkg: shared types and constants of the custom base number parser
// item layouts, register indexes, character codes and the whitespace test
// ----------------------------------------------------------------------------
package npcb_pkg;

    localparam int MAX_ALPHABET_DEF = 16;
    localparam int ALPHA_SLOTS      = 16;
    localparam int DIGIT_W          = 4;
    localparam int SIZE_W           = 5;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;
    localparam int ACC_W            = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] parsed_value;
        logic                    alphabet_bad;
    } t_out_item;

    // alphabet summary, refreshed every cycle from the config registers
    typedef struct packed {
        logic              bad;
        logic [SIZE_W-1:0] base;
    } t_alpha_info;

    // result of looking one byte up in the alphabet
    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] index;
    } t_digit;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

// ----- design/npcb_alpha_check.sv -----
// ----------------------------------------------------------------------------
// npcb_alpha_check: alphabet validity and effective base
// registered summary of the alphabet registers, taken from them
// ----------------------------------------------------------------------------
module npcb_alpha_check #(
    parameter int MAX_ALPHABET = npcb_pkg::MAX_ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [npcb_pkg::CFG_DATA_W-1:0] i_alpha_low,
    input  logic [npcb_pkg::CFG_DATA_W-1:0] i_alpha_high,
    input  logic [npcb_pkg::SIZE_W-1:0]   i_alpha_size,
    output npcb_pkg::t_alpha_info         o_info
);
    import npcb_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ALPHABET);

    logic [2*CFG_DATA_W-1:0] alpha;
    logic [7:0]              chars [MAX_ALPHABET];
    logic                    n_bad;
    logic [SIZE_W-1:0]       n_base;
    t_alpha_info             r_info;

    assign alpha = {i_alpha_high, i_alpha_low};

    always_comb begin
        for (int k = 0; k < MAX_ALPHABET; k++) begin
            chars[k] = alpha[8*k +: 8];
        end
    end

    always_comb begin
        n_base = (i_alpha_size > MAX_SIZE) ? MAX_SIZE : i_alpha_size;
        n_bad  = (i_alpha_size < SIZE_W'(2)) || (i_alpha_size > MAX_SIZE);
        for (int k = 0; k < MAX_ALPHABET; k++) begin
            if (SIZE_W'(k) < i_alpha_size) begin
                if ((chars[k] == CH_NUL) || (chars[k] == CH_PLUS) ||
                    (chars[k] == CH_MINUS) || is_space(chars[k])) begin
                    n_bad = 1'b1;
                end
                // duplicate pairs among the characters in use
                for (int m = k + 1; m < MAX_ALPHABET; m++) begin
                    if ((SIZE_W'(m) < i_alpha_size) && (chars[m] == chars[k])) begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info <= '0;
        end else begin
            r_info.bad  <= n_bad;
            r_info.base <= n_base;
        end
    end

    assign o_info = r_info;

endmodule

// ----- design/npcb_digit_lookup.sv -----
// ----------------------------------------------------------------------------
// npcb_digit_lookup: byte to digit value
// parallel compare against the characters in use, lowest position wins
// ----------------------------------------------------------------------------
module npcb_digit_lookup #(
    parameter int MAX_ALPHABET = npcb_pkg::MAX_ALPHABET_DEF
) (
    input  logic [7:0]                      i_char,
    input  logic [npcb_pkg::CFG_DATA_W-1:0] i_alpha_low,
    input  logic [npcb_pkg::CFG_DATA_W-1:0] i_alpha_high,
    input  logic [npcb_pkg::SIZE_W-1:0]     i_base,
    output npcb_pkg::t_digit                o_digit
);
    import npcb_pkg::*;

    logic [2*CFG_DATA_W-1:0] alpha;

    assign alpha = {i_alpha_high, i_alpha_low};

    always_comb begin
        o_digit = '0;
        // scan downward so the lowest matching position is the one left
        for (int k = MAX_ALPHABET - 1; k >= 0; k--) begin
            if ((SIZE_W'(k) < i_base) && (alpha[8*k +: 8] == i_char)) begin
                o_digit.hit   = 1'b1;
                o_digit.index = DIGIT_W'(k);
            end
        end
    end

endmodule

// ----- design/npcb_parse_core.sv -----
// ----------------------------------------------------------------------------
// npcb_parse_core: parse state and result register
// phase, sign and accumulator update per byte, result made on the last byte
// ----------------------------------------------------------------------------
module npcb_parse_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  npcb_pkg::t_in_item    i_item,
    input  npcb_pkg::t_digit      i_digit,
    input  npcb_pkg::t_alpha_info i_info,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output npcb_pkg::t_out_item   o_out_item
);
    import npcb_pkg::*;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_out_valid;
    t_out_item        r_out_item, n_out_item;
    logic             is_sign;

    assign is_sign = (i_item.char_code == CH_PLUS) || (i_item.char_code == CH_MINUS);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if ((r_phase == PH_SPACE) && is_space(i_item.char_code)) begin
            n_phase = PH_SPACE;
        end else if (((r_phase == PH_SPACE) || (r_phase == PH_SIGN)) && is_sign) begin
            n_phase = PH_SIGN;
            if (i_item.char_code == CH_MINUS) begin
                n_neg = ~r_neg;
            end
        end else if (r_phase != PH_DONE) begin
            if (i_digit.hit) begin
                n_phase = PH_DIGIT;
                n_acc   = ACC_W'(r_acc * ACC_W'(i_info.base)) + ACC_W'(i_digit.index);
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    always_comb begin
        n_out_item.alphabet_bad = i_info.bad;
        if (i_info.bad) begin
            n_out_item.parsed_value = '0;
        end else if (n_neg) begin
            n_out_item.parsed_value = -$signed(n_acc);
        end else begin
            n_out_item.parsed_value = $signed(n_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step) begin
                if (i_item.final_char) begin
                    r_phase <= PH_SPACE;
                    r_neg   <= 1'b0;
                    r_acc   <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_acc   <= n_acc;
                end
            end
            if (i_step && i_item.final_char) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_item.final_char) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- design/number_parse_custom_base_top.sv -----
// ----------------------------------------------------------------------------
// number_parse_custom_base_top: integer parser over a configurable alphabet
// bytes in, one signed 32-bit result per string, base set by the alphabet
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_stall | i_in_item  (char, final flag)
//  out      | output    | o_out_valid / i_out_stall| o_out_item (value, bad flag)
//  cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while the result is not stalled; the parse
//  step works on the byte while it sits in the input register, and the
//  result of its last byte is then captured in the result register
//  the rate is set by the combinational parse step: digit compare, a 32x5
//  multiply-add into the accumulator, then negate and select
//  reset (i_rst_n low at a clock edge) clears the parse state, the alphabet
//  registers and both valid flags
//  a stalled result holds; the input stalls only while a byte waits in the
//  input register behind a stalled result
//  alphabet validity is a registered summary taken from the alphabet registers
//
module number_parse_custom_base_top #(
    parameter int MAX_ALPHABET = npcb_pkg::MAX_ALPHABET_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  npcb_pkg::t_in_item                i_in_item,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output npcb_pkg::t_out_item               o_out_item,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [npcb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [npcb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import npcb_pkg::*;

    // alphabet registers
    logic [CFG_DATA_W-1:0] r_alpha_low;
    logic [CFG_DATA_W-1:0] r_alpha_high;
    logic [SIZE_W-1:0]     r_alpha_size;

    // input register
    logic                  r_s1_valid, n_s1_valid;
    t_in_item              r_s1_item;

    logic                  in_accept;
    logic                  out_blocked;
    logic                  step;
    t_alpha_info           alpha_info;
    t_digit                digit;

    // always ready, a write is registered straight into its alphabet register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
            r_alpha_size <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                CFG_ALPHA_SIZE: r_alpha_size <= i_cfg_data[SIZE_W-1:0];
                default:        ;  // unmapped index, write dropped
            endcase
        end
    end

    // the parse step moves whenever a byte is held and the result register can take its output
    assign out_blocked = o_out_valid && i_out_stall;
    assign step        = r_s1_valid && !out_blocked;
    assign o_in_stall  = r_s1_valid && out_blocked;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign n_s1_valid  = in_accept || (r_s1_valid && !step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
    end

    // registered validity and effective base
    npcb_alpha_check #(
        .MAX_ALPHABET (MAX_ALPHABET)
    ) u_alpha_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_alpha_low  (r_alpha_low),
        .i_alpha_high (r_alpha_high),
        .i_alpha_size (r_alpha_size),
        .o_info       (alpha_info)
    );

    // digit value of the byte in the input register
    npcb_digit_lookup #(
        .MAX_ALPHABET (MAX_ALPHABET)
    ) u_digit_lookup (
        .i_char       (r_s1_item.char_code),
        .i_alpha_low  (r_alpha_low),
        .i_alpha_high (r_alpha_high),
        .i_base       (alpha_info.base),
        .o_digit      (digit)
    );

    // parse state and result register
    npcb_parse_core u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_s1_item),
        .i_digit     (digit),
        .i_info      (alpha_info),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- design/npcb_checker.sv -----
// ----------------------------------------------------------------------------
// npcb_checker: port-level checks of the number parser
// bound to the top level, watches the handshakes and results
// ----------------------------------------------------------------------------
module npcb_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input npcb_pkg::t_out_item o_out_item
);
    import npcb_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a bad alphabet always forces a zero value
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.alphabet_bad) |-> (o_out_item.parsed_value == '0))
        else $error("nonzero value with bad alphabet");

    // the input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

bind number_parse_custom_base_top npcb_port_checker u_npcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
